@@ sv/rste_pkg.sv @@
// Shared types and constants for the range sum tree engine.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package rste_pkg;

    // Tree geometry
    localparam int MAX_ELEMENTS = 1024;
    localparam int NODE_W       = $clog2(2 * MAX_ELEMENTS);
    localparam int NODES        = 2 * MAX_ELEMENTS;

    // Field widths fixed by the interface
    localparam int POS_W = 10;
    localparam int VAL_W = 32;
    localparam int SUM_W = 48;
    localparam int CNT_W = 11;

    // Width for index arithmetic: holds 2*MAX_ELEMENTS and any count value
    localparam int EXT_W = (NODE_W + 1 > CNT_W + 1) ? NODE_W + 1 : CNT_W + 1;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1024);

    localparam logic KIND_SET   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture a request
        logic clear;     // write zero at the sweep address, advance it
        logic set_leaf;  // write the leaf, read its sibling
        logic set_read;  // read the sibling of the current node
        logic set_up;    // write the parent sum, move up one level
        logic q_init;    // set up both walk ends
        logic q_read;    // read the nodes at both walk ends
        logic q_acc;     // accumulate and move both ends up one level
        logic emit;      // drive the accumulated sum onto the result port
    } rste_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;  // sweep at the last entry
        logic is_query;  // captured request is a query
        logic set_ok;    // set position lies inside the count
        logic q_empty;   // clipped range holds no element
        logic root_next; // parent of the current node is the root
        logic q_done;    // walk ends have met
    } rste_stat_t;

endpackage

`default_nettype wire

@@ sv/rste_ctrl.sv @@
// Controller state machine for the range sum tree engine.
// Depends on rste_pkg for the command and status structs.
`default_nettype none

module rste_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire rste_pkg::rste_stat_t stat,
    output rste_pkg::rste_cmd_t      cmd,
    output logic                     busy,
    output logic                     done
);
    import rste_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SET_LEAF,
        S_SET_UP,
        S_SET_RD,
        S_Q_RD,
        S_Q_ACC
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   done_reg;

    // Decode commands and the next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_query)
                begin
                    if (stat.q_empty)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.q_init = 1'b1;
                        state_next = S_Q_RD;
                    end
                end
                else if (stat.set_ok)
                begin
                    state_next = S_SET_LEAF;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SET_LEAF:
            begin
                cmd.set_leaf = 1'b1;
                state_next   = S_SET_UP;
            end
            S_SET_UP:
            begin
                cmd.set_up = 1'b1;
                state_next = stat.root_next ? S_IDLE : S_SET_RD;
            end
            S_SET_RD:
            begin
                cmd.set_read = 1'b1;
                state_next   = S_SET_UP;
            end
            S_Q_RD:
            begin
                if (stat.q_done)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.q_read = 1'b1;
                    state_next = S_Q_ACC;
                end
            end
            S_Q_ACC:
            begin
                cmd.q_acc  = 1'b1;
                state_next = S_Q_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= cmd.emit;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ sv/rste_dpath.sv @@
// Datapath for the range sum tree engine: node store, walk registers, adders.
// Depends on rste_pkg for widths and the command and status structs.
`default_nettype none

module rste_dpath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rste_pkg::rste_cmd_t         cmd,
    output rste_pkg::rste_stat_t             stat,
    input  wire logic                        cfg_we,
    input  wire logic [rste_pkg::CNT_W-1:0]  cfg_data,
    input  wire logic                        kind,
    input  wire logic [rste_pkg::POS_W-1:0]  position,
    input  wire logic signed [rste_pkg::VAL_W-1:0] value,
    input  wire logic [rste_pkg::POS_W-1:0]  range_low,
    input  wire logic [rste_pkg::POS_W-1:0]  range_high,
    output logic signed [rste_pkg::SUM_W-1:0] range_sum
);
    import rste_pkg::*;

    localparam logic [EXT_W-1:0] MAX_E = EXT_W'(MAX_ELEMENTS);

    // Node store
    logic [SUM_W-1:0] mem [NODES];

    logic [CNT_W-1:0]  count_reg;
    logic [NODE_W-1:0] clr_reg;

    logic                     kind_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [VAL_W-1:0]  value_reg;
    logic [POS_W-1:0]         lo_reg;
    logic [POS_W-1:0]         hi_reg;
    logic [NODE_W-1:0]        node_reg;
    logic signed [SUM_W-1:0]  cur_reg;
    logic [EXT_W-1:0]         l_reg;
    logic [EXT_W-1:0]         r_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  rd_a_reg;
    logic signed [SUM_W-1:0]  rd_b_reg;

    logic [EXT_W-1:0]         cnt_e;
    logic [EXT_W-1:0]         pos_e;
    logic [EXT_W-1:0]         lo_e;
    logic [EXT_W-1:0]         hi_e;
    logic [EXT_W-1:0]         hi_clip;
    logic [EXT_W-1:0]         r_dec;
    logic [NODE_W-1:0]        parent;
    logic signed [SUM_W-1:0]  leaf_val;
    logic signed [SUM_W-1:0]  up_sum;
    logic signed [SUM_W-1:0]  add_a;
    logic signed [SUM_W-1:0]  add_b;
    logic                     mem_we;
    logic [NODE_W-1:0]        mem_waddr;
    logic [SUM_W-1:0]         mem_wdata;
    logic [NODE_W-1:0]        raddr_a;
    logic [NODE_W-1:0]        raddr_b;

    // Clip the count and the range, form the walk addresses and sums
    always_comb
    begin
        cnt_e   = (EXT_W'(count_reg) > MAX_E) ? MAX_E : EXT_W'(count_reg);
        pos_e   = EXT_W'(pos_reg);
        lo_e    = EXT_W'(lo_reg);
        hi_e    = EXT_W'(hi_reg);
        hi_clip = (hi_e > cnt_e - EXT_W'(1)) ? cnt_e - EXT_W'(1) : hi_e;
        r_dec   = r_reg - EXT_W'(1);
        parent  = node_reg >> 1;
        leaf_val = SUM_W'(value_reg);
        up_sum   = cur_reg + rd_a_reg;
        add_a    = l_reg[0] ? rd_a_reg : '0;
        add_b    = r_reg[0] ? rd_b_reg : '0;
    end

    // Report status to the controller
    always_comb
    begin
        stat.clr_last  = &clr_reg;
        stat.is_query  = (kind_reg == KIND_QUERY);
        stat.set_ok    = (pos_e < cnt_e);
        stat.q_empty   = (cnt_e == '0) || (lo_e > hi_clip);
        stat.root_next = (parent == NODE_W'(1));
        stat.q_done    = !(l_reg < r_reg);
    end

    // Select the write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        if (cmd.clear)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.set_leaf)
        begin
            mem_we    = 1'b1;
            mem_waddr = node_reg;
            mem_wdata = leaf_val;
        end
        else if (cmd.set_up)
        begin
            mem_we    = 1'b1;
            mem_waddr = parent;
            mem_wdata = up_sum;
        end
    end

    // Select the read addresses: sibling for a set walk, both ends for a query
    always_comb
    begin
        if (cmd.q_read)
        begin
            raddr_a = l_reg[NODE_W-1:0];
        end
        else
        begin
            raddr_a = node_reg ^ NODE_W'(1);
        end
        raddr_b = r_dec[NODE_W-1:0];
    end

    // Node store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    // Hold the count register and the clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_RESET;
            clr_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + NODE_W'(1);
            end
        end
    end

    // Capture requests and advance the walks
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            pos_reg   <= position;
            value_reg <= value;
            lo_reg    <= range_low;
            hi_reg    <= range_high;
            node_reg  <= NODE_W'(EXT_W'(position) + MAX_E);
            acc_reg   <= '0;
        end
        if (cmd.set_leaf)
        begin
            cur_reg <= leaf_val;
        end
        if (cmd.set_up)
        begin
            cur_reg  <= up_sum;
            node_reg <= parent;
        end
        if (cmd.q_init)
        begin
            l_reg <= lo_e + MAX_E;
            r_reg <= hi_clip + MAX_E + EXT_W'(1);
        end
        if (cmd.q_acc)
        begin
            acc_reg <= acc_reg + add_a + add_b;
            l_reg   <= (l_reg >> 1) + EXT_W'(l_reg[0]);
            r_reg   <= r_reg >> 1;
        end
        if (cmd.emit)
        begin
            sum_reg <= acc_reg;
        end
    end

    assign range_sum = sum_reg;

endmodule

`default_nettype wire

@@ sv/range_sum_tree_engine.sv @@
// Range sum tree engine: a set walks from the leaf to the root, one sibling read then a parent
// write per tree level, and the next request is taken once busy falls.
// A query runs up to eleven read and add rounds, both walk ends read from the two-port node
// store; done pulses with range_sum when the walk ends, at the edge that may already take the
// next request. One request at a time; done cannot be held off. Reset clears the 2048-entry
// store, busy high meanwhile; element_count resets to 1024 and the configuration port is always
// ready.
`default_nettype none

module range_sum_tree_engine (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         kind,
    input  wire logic [rste_pkg::POS_W-1:0]   position,
    input  wire logic signed [rste_pkg::VAL_W-1:0] value,
    input  wire logic [rste_pkg::POS_W-1:0]   range_low,
    input  wire logic [rste_pkg::POS_W-1:0]   range_high,
    output logic                              done,
    output logic signed [rste_pkg::SUM_W-1:0] range_sum,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [rste_pkg::CNT_W-1:0]   cfg_data
);
    import rste_pkg::*;

    rste_cmd_t  cmd;
    rste_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequence the walks
    rste_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Store the tree and do the sums
    rste_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .position   (position),
        .value      (value),
        .range_low  (range_low),
        .range_high (range_high),
        .range_sum  (range_sum)
    );

endmodule

`default_nettype wire

@@ tb/range_sum_tree_engine_test.sv @@
// Self-checking testbench for range_sum_tree_engine: point writes and range sums
// against a sum tree kept in the testbench. Depends on rste_pkg and the engine RTL.

module range_sum_tree_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rste_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_REQUESTS = 160;

    typedef struct {
        logic                    kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        range_low;
        logic [POS_W-1:0]        range_high;
    } tree_request_t;

    // Block ports
    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    start      = 1'b0;
    logic                    busy;
    logic                    kind       = KIND_SET;
    logic [POS_W-1:0]        position   = '0;
    logic signed [VAL_W-1:0] value      = '0;
    logic [POS_W-1:0]        range_low  = '0;
    logic [POS_W-1:0]        range_high = '0;
    logic                    done;
    logic signed [SUM_W-1:0] range_sum;
    logic                    cfg_valid  = 1'b0;
    logic                    cfg_ready;
    logic [CNT_W-1:0]        cfg_data   = '0;

    // Testbench state
    tree_request_t           pending_requests[$];
    logic signed [SUM_W-1:0] sums_waiting[$];
    logic signed [SUM_W-1:0] sum_tree[NODES];
    logic [CNT_W-1:0]        element_count;
    logic                    request_taken = 1'b0;
    logic                    idle_enabled  = 1'b1;
    logic                    mismatch_seen = 1'b0;
    int                      idle_left     = 0;
    int                      cycle_count   = 0;

    range_sum_tree_engine DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .position   (position),
        .value      (value),
        .range_low  (range_low),
        .range_high (range_high),
        .done       (done),
        .range_sum  (range_sum),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Write one element and rebuild its ancestors bottom-up
    function automatic void store_element(input int unsigned slot,
                                          input logic signed [SUM_W-1:0] element);
        int unsigned node;
        node = slot + MAX_ELEMENTS;
        sum_tree[node] = element;
        while (node > 1)
        begin
            node = node >> 1;
            sum_tree[node] = sum_tree[2 * node] + sum_tree[2 * node + 1];
        end
    endfunction

    // Add up the nodes covering an inclusive element span
    function automatic logic signed [SUM_W-1:0] span_total(input int unsigned first,
                                                           input int unsigned last);
        int unsigned             l;
        int unsigned             r;
        logic signed [SUM_W-1:0] acc;
        l   = first + MAX_ELEMENTS;
        r   = last + MAX_ELEMENTS + 1;
        acc = '0;
        while (l < r)
        begin
            if (l & 1)
            begin
                acc = acc + sum_tree[l];
                l   = l + 1;
            end
            if (r & 1)
            begin
                r   = r - 1;
                acc = acc + sum_tree[r];
            end
            l = l >> 1;
            r = r >> 1;
        end
        return acc;
    endfunction

    // Apply one accepted request to the tree, queue the sum a query returns
    function automatic void apply_request(input tree_request_t req);
        int unsigned             in_use;
        int unsigned             last;
        logic signed [SUM_W-1:0] element;
        logic signed [SUM_W-1:0] total;
        in_use = (element_count > MAX_ELEMENTS) ? MAX_ELEMENTS : element_count;
        if (req.kind == KIND_SET)
        begin
            element = req.value;
            if (req.position < in_use)
                store_element(req.position, element);
        end
        else
        begin
            total = '0;
            if (in_use > 0)
            begin
                last = (req.range_high > in_use - 1) ? in_use - 1 : req.range_high;
                if (req.range_low <= last)
                    total = span_total(req.range_low, last);
            end
            sums_waiting.push_back(total);
        end
    endfunction

    // Monitor: sample at the rising edge, predict accepted requests, check sums
    always @(posedge clk)
    begin
        tree_request_t req;
        logic signed [SUM_W-1:0] wanted;
        if (!rst_n)
        begin
            request_taken = 1'b0;
        end
        else
        begin
            request_taken = start && !busy;
            if (cfg_valid && cfg_ready)
                element_count = cfg_data;
            if (done)
            begin
                if (sums_waiting.size() == 0)
                begin
                    $error("range_sum with no request waiting: actual %0d", range_sum);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    wanted = sums_waiting.pop_front();
                    if (range_sum !== wanted)
                    begin
                        $error("range_sum mismatch: expected %0d, actual %0d",
                               wanted, range_sum);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            if (request_taken)
            begin
                req.kind       = kind;
                req.position   = position;
                req.value      = value;
                req.range_low  = range_low;
                req.range_high = range_high;
                apply_request(req);
            end
        end
    end

    // Driver: hold a request until taken, then present the next one or idle
    always @(negedge clk)
    begin
        tree_request_t next_req;
        logic present;
        present = 1'b0;
        if (rst_n && (!start || request_taken))
        begin
            if (idle_left > 0)
                idle_left = idle_left - 1;
            else if (pending_requests.size() > 0)
            begin
                if (idle_enabled && $urandom_range(0, 99) < 7)
                    idle_left = $urandom_range(0, 23);
                else
                    present = 1'b1;
            end
            if (present)
            begin
                next_req = pending_requests.pop_front();
                kind       <= next_req.kind;
                position   <= next_req.position;
                value      <= next_req.value;
                range_low  <= next_req.range_low;
                range_high <= next_req.range_high;
                start      <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_request(input logic req_kind, input int unsigned pos,
                                 input logic signed [VAL_W-1:0] val,
                                 input int unsigned lo, input int unsigned hi);
        tree_request_t req;
        req.kind       = req_kind;
        req.position   = pos[POS_W-1:0];
        req.value      = val;
        req.range_low  = lo[POS_W-1:0];
        req.range_high = hi[POS_W-1:0];
        pending_requests.push_back(req);
    endtask

    // Wait until every request is taken and answered, then let a set finish
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || start || sums_waiting.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input int unsigned count_value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= count_value[CNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        int unsigned phase_counts[10];
        int unsigned in_use;
        int unsigned pick_span;
        int unsigned a;
        int unsigned b;
        logic        req_kind;
        int unsigned pos;
        logic signed [VAL_W-1:0] val;

        phase_counts = '{1, 1024, 0, 2047, 2, 1025, 300, 1, 777, 1024};
        for (int n = 0; n < NODES; n++)
            sum_tree[n] = '0;
        element_count = CNT_RESET;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty tree, value extremes at both ends and empty ranges
        queue_request(KIND_QUERY, 1023, 32'sd0, 0, 1023);
        queue_request(KIND_SET, 0, 32'sh7FFFFFFF, 1023, 0);
        queue_request(KIND_SET, 1023, 32'sh80000000, 511, 3);
        queue_request(KIND_SET, 512, -32'sd1, 0, 0);
        queue_request(KIND_SET, 1, 32'sh7FFFFFFF, 1023, 1023);
        queue_request(KIND_QUERY, 777, 32'sh7FFFFFFF, 0, 1023);
        queue_request(KIND_QUERY, 0, 32'sd0, 1023, 0);
        queue_request(KIND_QUERY, 1023, -32'sd1, 0, 0);
        queue_request(KIND_QUERY, 5, 32'sd17, 1023, 1023);
        queue_request(KIND_QUERY, 0, 32'sd0, 0, 1);
        queue_request(KIND_QUERY, 0, 32'sd0, 512, 512);
        queue_request(KIND_SET, 512, 32'sd0, 0, 0);
        queue_request(KIND_QUERY, 0, 32'sd0, 1, 1023);
        queue_request(KIND_SET, 341, 32'sh55555555, 682, 341);
        queue_request(KIND_SET, 682, 32'shAAAAAAAA, 341, 682);
        queue_request(KIND_QUERY, 341, 32'sd0, 341, 682);
        queue_request(KIND_QUERY, 0, 32'sd0, 342, 681);
        queue_request(KIND_QUERY, 0, 32'sd0, 0, 1023);
        wait_drained();

        // Random phases over a range of counts, extremes included
        for (int ph = 0; ph < 10; ph++)
        begin
            write_count(phase_counts[ph]);
            in_use       = (phase_counts[ph] > MAX_ELEMENTS) ? MAX_ELEMENTS : phase_counts[ph];
            pick_span    = (in_use == 0) ? 1 : in_use;
            idle_enabled = (ph % 3 != 1);
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                req_kind = ($urandom_range(0, 99) < 55) ? KIND_QUERY : KIND_SET;
                if ($urandom_range(0, 9) < 8)
                    pos = $urandom_range(0, pick_span - 1);
                else
                    pos = $urandom_range(0, MAX_ELEMENTS - 1);
                case ($urandom_range(0, 7))
                    0:       val = 32'sh7FFFFFFF;
                    1:       val = 32'sh80000000;
                    2:       val = $signed(32'($urandom_range(0, 200))) - 32'sd100;
                    default: val = $urandom;
                endcase
                if ($urandom_range(0, 9) < 7)
                begin
                    a = $urandom_range(0, pick_span - 1);
                    b = $urandom_range(0, pick_span - 1);
                end
                else
                begin
                    a = $urandom_range(0, MAX_ELEMENTS - 1);
                    b = $urandom_range(0, MAX_ELEMENTS - 1);
                end
                if ($urandom_range(0, 9) < 8 && a > b)
                    queue_request(req_kind, pos, val, b, a);
                else
                    queue_request(req_kind, pos, val, a, b);
            end
            wait_drained();
        end

        if (!mismatch_seen)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
